// ----- rtl/isc_pkg.sv -----
// shared types, constants and the residue class decoder for the site classifier
// no dependencies; used by every module in rtl/
package isc_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int CLS_W       = 3;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 16;
  localparam int COL_W       = 16;
  localparam int CHAR_W      = 8;
  localparam int DEPTH_W     = 13;
  localparam int THRESH_W    = 17;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CNT_W-1:0]  MAX_SEQUENCES = CNT_W'(4096);
  localparam logic [CHAR_W-1:0] GAP_CHAR      = 8'h2d;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DEPTH      = 2'd0,
    REG_VAR_THRESHOLD  = 2'd1
  } cfg_reg_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_LA = 3'd0, CLS_LT = 3'd1, CLS_LG = 3'd2, CLS_LC = 3'd3,
    CLS_UA = 3'd4, CLS_UT = 3'd5, CLS_UC = 3'd6, CLS_UG = 3'd7
  } cls_code_t;

  typedef struct packed {
    logic      hit;
    cls_code_t idx;
  } cls_t;

  typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] counts_t;

  // finished column handed from the counter to the judge
  typedef struct packed {
    counts_t           counts;
    logic [CHAR_W-1:0] ref_char;
    logic [COL_W-1:0]  col;
  } snap_t;

  // column summary after the reduction stage
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] mx;
    logic             basic_ok;
    logic [COL_W-1:0] col;
  } red_t;

  function automatic cls_t class_of(input logic [CHAR_W-1:0] ch);
    cls_t c;
    c.hit = 1'b1;
    c.idx = CLS_LA;
    case (ch)
      8'h61:   c.idx = CLS_LA;
      8'h74:   c.idx = CLS_LT;
      8'h67:   c.idx = CLS_LG;
      8'h63:   c.idx = CLS_LC;
      8'h41:   c.idx = CLS_UA;
      8'h54:   c.idx = CLS_UT;
      8'h43:   c.idx = CLS_UC;
      8'h47:   c.idx = CLS_UG;
      default: c.hit = 1'b0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/isc_counter.sv -----
// per-class residue counters and column counter; hands each finished column on
// depends on isc_pkg
module isc_counter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [isc_pkg::CHAR_W-1:0] residue,
  input  logic [isc_pkg::CHAR_W-1:0] ref_char,
  input  logic                      last,
  output logic                      snap_valid,
  input  logic                      snap_ready,
  output isc_pkg::snap_t            snap
);
  import isc_pkg::*;

  counts_t          counts_r, counts_nxt, counts_upd;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             snap_valid_r, snap_valid_nxt;
  snap_t            snap_r;
  cls_t             cls;
  logic             accept;

  assign in_ready = !snap_valid_r || snap_ready;
  assign accept   = in_valid && in_ready;
  assign cls      = class_of(residue);

  always_comb begin
    counts_upd = counts_r;
    if (cls.hit && (counts_r[cls.idx] < MAX_SEQUENCES)) begin
      counts_upd[cls.idx] = counts_r[cls.idx] + CNT_W'(1);
    end
  end

  always_comb begin
    counts_nxt = counts_r;
    col_nxt    = col_r;
    if (accept) begin
      if (last) begin
        counts_nxt = '0;
        col_nxt    = col_r + COL_W'(1);
      end else begin
        counts_nxt = counts_upd;
      end
    end
  end

  always_comb begin
    snap_valid_nxt = snap_valid_r;
    if (in_ready) begin
      snap_valid_nxt = accept && last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r     <= '0;
      col_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      counts_r     <= counts_nxt;
      col_r        <= col_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  // the last word's residue is counted before the column is snapped
  always_ff @(posedge clk) begin
    if (accept && last) begin
      snap_r.counts   <= counts_upd;
      snap_r.ref_char <= ref_char;
      snap_r.col      <= col_r;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (counts_r == '0))
    else $error("class counters not cleared after last word");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (col_r == $past(col_r) + COL_W'(1)))
    else $error("column counter did not advance");

  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && last) |=> (col_r == $past(col_r)))
    else $error("column counter moved without a last word");
`endif

endmodule

// ----- rtl/isc_judge.sv -----
// column judgment: reduction stage (sum, max, class, depth and gap tests) then
// threshold stage with the result register; depends on isc_pkg
module isc_judge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  isc_pkg::snap_t               snap,
  input  logic [isc_pkg::DEPTH_W-1:0]  min_depth,
  input  logic [isc_pkg::THRESH_W-1:0] var_threshold,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [isc_pkg::COL_W-1:0]    column_index,
  output logic                         informative,
  output logic                         high_variability
);
  import isc_pkg::*;

  logic                          red_valid_r;
  red_t                          red_r, red_nxt;
  logic                          out_valid_r;
  logic [COL_W-1:0]              col_r;
  logic                          inf_r, high_r;
  logic                          en_out, en_red;
  logic [SUM_W-1:0]              sum_c;
  logic [CNT_W-1:0]              mx_c;
  logic [NUM_CLASSES-1:0]        present_c, repeated_c;
  logic [SUM_W-1:0]              minor_c;
  logic [FRAC_W+SUM_W:0]         lhs_c, rhs_c;
  logic                          high_c;

  assign en_out     = !out_valid_r || out_ready;
  assign en_red     = !red_valid_r || en_out;
  assign snap_ready = en_red;

  always_comb begin
    sum_c = '0;
    mx_c  = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sum_c         = sum_c + SUM_W'(snap.counts[k]);
      present_c[k]  = (snap.counts[k] != '0);
      repeated_c[k] = (snap.counts[k] > CNT_W'(1));
      if (snap.counts[k] > mx_c) begin
        mx_c = snap.counts[k];
      end
    end
  end

  always_comb begin
    red_nxt.sum      = sum_c;
    red_nxt.mx       = mx_c;
    red_nxt.col      = snap.col;
    red_nxt.basic_ok = ($countones(present_c) > 1) && ($countones(repeated_c) > 1) &&
                       (sum_c > SUM_W'(min_depth)) && (snap.ref_char != GAP_CHAR);
  end

  // exact test of (sum - max) / sum > threshold / 2^16
  assign minor_c = red_r.sum - SUM_W'(red_r.mx);
  assign lhs_c   = (FRAC_W+SUM_W+1)'({minor_c, {FRAC_W{1'b0}}});
  assign rhs_c   = (FRAC_W+SUM_W+1)'(var_threshold * red_r.sum);
  assign high_c  = red_r.basic_ok && (lhs_c > rhs_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_red) begin
        red_valid_r <= snap_valid;
      end
      if (en_out) begin
        out_valid_r <= red_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_red && snap_valid) begin
      red_r <= red_nxt;
    end
    if (en_out && red_valid_r) begin
      col_r  <= red_r.col;
      inf_r  <= red_r.basic_ok;
      high_r <= high_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign column_index     = col_r;
  assign informative      = inf_r;
  assign high_variability = high_r;

`ifndef SYNTHESIS
  a_high_needs_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!high_r || inf_r))
    else $error("high variability flagged on a non-informative column");

  a_stall_holds_red: assert property (@(posedge clk) disable iff (!rst_n)
    (red_valid_r && !en_out) |=> (red_valid_r && $stable(red_r)))
    else $error("reduction stage lost a column during a stall");
`endif

endmodule

// ----- rtl/informative_site_classifier.sv -----
// top level of the parsimony-informative site classifier
// depends on isc_pkg, isc_counter, isc_judge
//
// usage:
//   in_*  : one residue per word, columns streamed one after another.
//           in_tdata[7:0] residue, in_tdata[15:8] reference character,
//           in_tlast marks the last residue of a column.
//   out_* : one word per finished column (only on in_tlast words).
//   cfg_* : register writes, index 0 min_depth, index 1 threshold (Q1.16);
//           other indexes are dropped. cfg_ready is always high.
// timing:
//   one word per cycle sustained while out_tready stays high. the result of a
//   column reaches out_tvalid through the counter snapshot, the reduction
//   stage and the threshold stage with the result register.
//   the threshold stage holds one 17x16 multiply.
// reset: counts, column index and config registers go to zero, no word pending.
// stall: a held result keeps its value; two more finished columns wait in the
//   pipe, and once the counter's snapshot is full in_tready stays low.
module informative_site_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [isc_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] residue, [15:8] reference_char
  input  logic                            in_tlast,   // last_in_column
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] column_index, [16] informative, [17] high_variability, [23:18] zero
  output logic [isc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [isc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import isc_pkg::*;

  logic [DEPTH_W-1:0]  min_depth_r;
  logic [THRESH_W-1:0] thresh_r;
  logic                snap_valid, snap_ready;
  snap_t               snap;
  logic [COL_W-1:0]    column_index;
  logic                informative, high_variability;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= '0;
      thresh_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DEPTH:     min_depth_r <= cfg_data[DEPTH_W-1:0];
        REG_VAR_THRESHOLD: thresh_r    <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  isc_counter u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .residue    (in_tdata[CHAR_W-1:0]),
    .ref_char   (in_tdata[2*CHAR_W-1:CHAR_W]),
    .last       (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  isc_judge u_judge (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap),
    .min_depth        (min_depth_r),
    .var_threshold    (thresh_r),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .column_index     (column_index),
    .informative      (informative),
    .high_variability (high_variability)
  );

  assign out_tdata = {(OUT_DATA_W-COL_W-2)'(0), high_variability, informative, column_index};

endmodule

// ----- bench/tb.sv -----
// testbench for informative_site_classifier: directed and random alignment columns
// checked against a scoreboard that models class counting and site judging
// depends on rtl/isc_pkg.sv and rtl/informative_site_classifier.sv
`timescale 1ns / 1ps

module tb;
  import isc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int SEQ_LIMIT   = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CHAR_W-1:0] BASES [NUM_CLASSES] =
    '{"a", "t", "g", "c", "A", "T", "C", "G"};

  class site_scoreboard;
    typedef struct {
      logic [COL_W-1:0] col;
      logic             informative;
      logic             high;
    } verdict_t;

    int unsigned         counts [NUM_CLASSES];
    logic [COL_W-1:0]    col_idx;
    logic [DEPTH_W-1:0]  min_depth;
    logic [THRESH_W-1:0] threshold;
    verdict_t            verdicts [$];
    int                  errors;

    function new();
      foreach (counts[k]) counts[k] = 0;
      col_idx   = '0;
      min_depth = '0;
      threshold = '0;
      errors    = 0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MIN_DEPTH) min_depth = data[DEPTH_W-1:0];
      else if (idx == REG_VAR_THRESHOLD) threshold = data[THRESH_W-1:0];
    endfunction

    function int base_class(logic [CHAR_W-1:0] ch);
      case (ch)
        "a":     return CLS_LA;
        "t":     return CLS_LT;
        "g":     return CLS_LG;
        "c":     return CLS_LC;
        "A":     return CLS_UA;
        "T":     return CLS_UT;
        "C":     return CLS_UC;
        "G":     return CLS_UG;
        default: return -1;
      endcase
    endfunction

    // count the residue; on the last word of a column judge it and queue the verdict
    function void note_word(logic [CHAR_W-1:0] residue, logic [CHAR_W-1:0] ref_char,
                            logic last);
      int k;
      int present;
      int repeated;
      int unsigned mx;
      int unsigned total;
      longint unsigned minor_scaled;
      longint unsigned bar;
      verdict_t v;
      k = base_class(residue);
      if (k >= 0 && counts[k] < SEQ_LIMIT) counts[k]++;
      if (!last) return;
      present  = 0;
      repeated = 0;
      mx       = 0;
      total    = 0;
      for (int j = 0; j < NUM_CLASSES; j++) begin
        if (counts[j] > 0) present++;
        if (counts[j] > 1) repeated++;
        if (counts[j] > mx) mx = counts[j];
        total += counts[j];
      end
      v.col = col_idx;
      v.informative = present > 1 && total > min_depth && repeated > 1 &&
                      ref_char != GAP_CHAR;
      minor_scaled = longint'(total - mx) << 16;
      bar = longint'(threshold) * total;
      v.high = v.informative && minor_scaled > bar;
      verdicts = {verdicts, v};
      foreach (counts[j]) counts[j] = 0;
      col_idx++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (word[15:0] !== want.col) begin
        $display("%0t: column_index expected %0d actual %0d", $time, want.col, word[15:0]);
        errors++;
      end
      if (word[16] !== want.informative) begin
        $display("%0t: informative (column %0d) expected %b actual %b",
                 $time, want.col, want.informative, word[16]);
        errors++;
      end
      if (word[17] !== want.high) begin
        $display("%0t: high_variability (column %0d) expected %b actual %b",
                 $time, want.col, want.high, word[17]);
        errors++;
      end
      if (word[23:18] !== '0) begin
        $display("%0t: padding expected 0 actual %h", $time, word[23:18]);
        errors++;
      end
    endfunction

    function void report_leftover();
      $display("%0t: %0d results still expected, expected column %0d, actual none",
               $time, verdicts.size(), verdicts[0].col);
      errors++;
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  site_scoreboard sb;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  informative_site_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata[7:0], in_tdata[15:8], in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !(rx_idle_en && $urandom_range(99) < 27);
      end
    end
  end

  initial begin
    #(64'd12 * 64'd2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_word(input logic [CHAR_W-1:0] residue,
                           input logic [CHAR_W-1:0] ref_char, input logic last);
    while (tx_idle_en && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ref_char, residue};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic [CHAR_W-1:0] ref_char);
    for (int i = 0; i < s.len(); i++) send_word(s[i], ref_char, i == s.len() - 1);
  endtask

  // mostly a small palette of bases so that many columns turn out informative
  task automatic random_column(input int depth);
    logic [CHAR_W-1:0] pal [3];
    logic [CHAR_W-1:0] res;
    logic [CHAR_W-1:0] rc;
    int n_pal;
    int r;
    n_pal = $urandom_range(1, 3);
    foreach (pal[i]) pal[i] = BASES[$urandom_range(NUM_CLASSES - 1)];
    for (int i = 0; i < depth; i++) begin
      r = $urandom_range(99);
      if (r < 85) res = pal[$urandom_range(n_pal - 1)];
      else if (r < 95) res = BASES[$urandom_range(NUM_CLASSES - 1)];
      else res = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 90) rc = BASES[$urandom_range(NUM_CLASSES - 1)];
      else if (r < 97) rc = GAP_CHAR;
      else rc = 8'($urandom_range(255));
      send_word(res, rc, i == depth - 1);
    end
  endtask

  // wait for all verdicts, then let the counting stage go quiet
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) sb.report_leftover();
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] depth_word,
                           input logic [CFG_DATA_W-1:0] thr_word);
    settle();
    if ($urandom_range(1)) cfg_beat(REG_SPARE_2, CFG_DATA_W'($urandom));
    cfg_beat(REG_MIN_DEPTH, depth_word);
    if ($urandom_range(1)) cfg_beat(REG_SPARE_3, CFG_DATA_W'($urandom));
    cfg_beat(REG_VAR_THRESHOLD, thr_word);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(input int words);
    int n;
    int depth;
    n = 0;
    while (n < words) begin
      depth = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      random_column(depth);
      n += depth;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dw;
    logic [CFG_DATA_W-1:0] tw;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty columns with extreme field values
    send_word(8'hff, 8'h00, 1'b1);
    send_word(8'h00, 8'hff, 1'b0);
    send_word("N", "A", 1'b1);
    // last residue makes the second class repeated
    send_text("aatt", "A");
    send_text("aatt", GAP_CHAR);
    // case kept apart
    send_text("aAaA", "c");
    send_text("GGGG", "g");
    send_text("cCgT", "a");

    // depth and threshold boundaries on strict compares
    configure(17'd4, 17'd32768);
    send_text("aatt", "T");
    send_text("aattc", "T");
    configure(17'd3, 17'd32768);
    send_text("aatt", "T");
    configure(17'd3, 17'd32767);
    send_text("aatt", "T");

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin dw = 17'd0; tw = 17'd0; end
        1: begin dw = 17'h1ffff; tw = 17'h1ffff; end
        2: begin dw = 17'd3; tw = 17'd65536; end
        3: begin dw = 17'($urandom_range(6)); tw = 17'($urandom_range(65536)); end
        4: begin dw = {4'($urandom), 13'($urandom_range(4))}; tw = 17'($urandom); end
        5: begin dw = 17'd0; tw = 17'($urandom); end
        6: begin dw = 17'd1; tw = 17'd16384; end
        default: begin dw = 17'd2; tw = 17'h08000; end
      endcase
      configure(dw, tw);
      if (phase == 6) begin
        // the result side stalls while short columns keep coming
        hold_req = 1'b1;
        repeat (30) random_column($urandom_range(1, 3));
      end
      random_phase(60);
    end

    // a long stretch with no idling on either side
    settle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_phase(100);
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    configure(17'($urandom_range(4)), 17'($urandom_range(65536)));
    random_phase(60);
    settle();

    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
